// ===== rtl/ppf_pkg.sv =====
package ppf_pkg;

  // Command codes carried in the opcode field.
  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_POP  = 2'd1;
  localparam logic [1:0] OP_AGE  = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // Selection policy codes.
  localparam logic [1:0] POL_DEPTH    = 2'd0;
  localparam logic [1:0] POL_SEVERITY = 2'd1;
  localparam logic [1:0] POL_LOCALITY = 2'd2;
  localparam logic [1:0] POL_HIER     = 2'd3;

  localparam logic [15:0] AGE_MAX = 16'hFFFF;

  // One stored work item.
  typedef struct packed {
    logic [7:0]  depth;
    logic [7:0]  severity;
    logic [7:0]  locality;
    logic [7:0]  weight;
    logic [15:0] age;
    logic [15:0] id;
  } ppf_entry_t;

  // Input transaction payload.
  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  item_depth;
    logic [7:0]  severity;
    logic [7:0]  locality;
    logic [7:0]  weight;
    logic [15:0] age_in;
    logic [15:0] item_id;
  } ppf_in_t;

  // Output transaction payload.
  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  out_depth;
    logic [7:0]  out_severity;
    logic [7:0]  out_locality;
    logic [7:0]  out_weight;
    logic [15:0] out_age;
    logic [15:0] out_id;
    logic [6:0]  occupancy;
  } ppf_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;
    logic       push;
    logic       scan_start;
    logic       scan;
    logic       age_mode;
    logic       pop_finish;
    logic       set_res;
    logic [1:0] res_code;
    logic       emit;
  } ppf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] op;
    logic       full;
    logic       empty;
    logic       scan_last;
    logic       out_free;
  } ppf_status_t;

  // True when entry a is preferred over entry b under the given policy.
  function automatic logic ppf_wins(ppf_entry_t a, ppf_entry_t b, logic [1:0] pol);
    logic res;
    logic decided;
    res     = 1'b0;
    decided = 1'b0;
    case (pol)
      POL_DEPTH: begin
        if (a.depth != b.depth) begin
          res     = (a.depth < b.depth);
          decided = 1'b1;
        end
      end
      POL_SEVERITY: begin
        if (a.severity != b.severity) begin
          res     = (a.severity > b.severity);
          decided = 1'b1;
        end
      end
      POL_LOCALITY: begin
        if (a.locality != b.locality) begin
          res     = (a.locality > b.locality);
          decided = 1'b1;
        end
      end
      default: begin
        if (a.depth != b.depth) begin
          res     = (a.depth < b.depth);
          decided = 1'b1;
        end else if (a.weight != b.weight) begin
          res     = (a.weight > b.weight);
          decided = 1'b1;
        end else if (a.locality != b.locality) begin
          res     = (a.locality > b.locality);
          decided = 1'b1;
        end
      end
    endcase
    // Remaining ties go to the older entry, then to the smaller id.
    if (!decided) begin
      if (a.age != b.age) begin
        res = (a.age > b.age);
      end else begin
        res = (a.id < b.id);
      end
    end
    return res;
  endfunction

endpackage

// ===== rtl/policy_priority_frontier_core.sv =====
// Sequence: push, refused pop, age of an empty store and the unused opcode go from the load
// through decode straight to emit; pop and age add a scan of the N stored entries in between.
// Throughput: one transaction at a time, the next accepted once the controller is back in idle
// after the result is registered; pop and age take longer with N, as the single read port
// scans one entry per cycle. A stalled result holds off the input.
// Reset clears control, entry count and sets the hierarchical policy; entries need no clearing.
module policy_priority_frontier_core
  import ppf_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  ppf_in_t    in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output ppf_out_t   out_data_o,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_wdata_i
);

  ppf_cmd_t    cmd;
  ppf_status_t status;

  // Sequencer for each command.
  ppf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Entry store, search and result registers.
  ppf_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== rtl/ppf_ctrl.sv =====
module ppf_ctrl
  import ppf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  ppf_status_t status_i,
  output ppf_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_AGE,
    S_EMIT
  } state_e;

  state_e state_q, state_d;

  // New transactions are taken only between commands.
  assign in_stall_o = (state_q != S_IDLE);

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        case (status_i.op)
          OP_PUSH: begin
            cmd_o.set_res = 1'b1;
            if (status_i.full) begin
              cmd_o.res_code = ST_FULL;
            end else begin
              cmd_o.push     = 1'b1;
              cmd_o.res_code = ST_DONE;
            end
            state_d = S_EMIT;
          end
          OP_POP: begin
            if (status_i.empty) begin
              cmd_o.set_res  = 1'b1;
              cmd_o.res_code = ST_EMPTY;
              state_d        = S_EMIT;
            end else begin
              cmd_o.scan_start = 1'b1;
              state_d          = S_SCAN;
            end
          end
          OP_AGE: begin
            if (status_i.empty) begin
              cmd_o.set_res  = 1'b1;
              cmd_o.res_code = ST_DONE;
              state_d        = S_EMIT;
            end else begin
              cmd_o.scan_start = 1'b1;
              state_d          = S_AGE;
            end
          end
          default: begin
            cmd_o.set_res  = 1'b1;
            cmd_o.res_code = ST_DONE;
            state_d        = S_EMIT;
          end
        endcase
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (status_i.scan_last) begin
          cmd_o.pop_finish = 1'b1;
          state_d          = S_EMIT;
        end
      end
      S_AGE: begin
        cmd_o.scan     = 1'b1;
        cmd_o.age_mode = 1'b1;
        if (status_i.scan_last) begin
          cmd_o.set_res  = 1'b1;
          cmd_o.res_code = ST_DONE;
          state_d        = S_EMIT;
        end
      end
      S_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/ppf_datapath.sv =====
module ppf_datapath
  import ppf_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ppf_in_t     in_data_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_wdata_i,
  input  ppf_cmd_t    cmd_i,
  output ppf_status_t status_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output ppf_out_t    out_data_o
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  // Entry storage: one write port and one registered read port.
  ppf_entry_t mem [CAPACITY];

  logic [1:0]  policy_q;
  ppf_in_t     item_q;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] idx_q, idx_d;
  logic          rd_en;
  logic          rd_vld_q;
  logic [AW-1:0] rd_idx_q;
  ppf_entry_t    rd_data_q;
  ppf_entry_t    best_q, best_d;
  logic [AW-1:0] best_idx_q, best_idx_d;
  logic          scan_last;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  ppf_entry_t    wr_data;
  ppf_entry_t    push_entry;
  ppf_entry_t    aged_entry;
  logic [1:0]    res_status_q;
  ppf_entry_t    res_item_q;
  ppf_out_t      out_q;
  logic          out_vld_q;

  // Policy register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= POL_HIER;
    end else if (cfg_we_i) begin
      policy_q <= cfg_wdata_i;
    end
  end

  // Capture of the accepted transaction.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_data_i;
    end
  end

  assign push_entry = '{depth:    item_q.item_depth,
                        severity: item_q.severity,
                        locality: item_q.locality,
                        weight:   item_q.weight,
                        age:      item_q.age_in,
                        id:       item_q.item_id};

  // Scan address issue: one read per cycle until every stored entry is read.
  assign rd_en = cmd_i.scan && (idx_q < count_q);
  assign idx_d = cmd_i.scan_start ? '0 : (rd_en ? idx_q + CW'(1) : idx_q);
  assign scan_last = rd_vld_q && (CW'(rd_idx_q) == count_q - CW'(1));

  // Best entry so far; the first entry read seeds the search.
  always_comb begin
    best_d     = best_q;
    best_idx_d = best_idx_q;
    if (rd_vld_q && ((rd_idx_q == '0) || ppf_wins(rd_data_q, best_q, policy_q))) begin
      best_d     = rd_data_q;
      best_idx_d = rd_idx_q;
    end
  end

  // Saturating age step for the entry just read.
  always_comb begin
    aged_entry = rd_data_q;
    if (rd_data_q.age != AGE_MAX) begin
      aged_entry.age = rd_data_q.age + 16'd1;
    end
  end

  // Write port selection: push, refill of the freed slot, or age update.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = rd_idx_q;
    wr_data = aged_entry;
    if (cmd_i.push) begin
      wr_en   = 1'b1;
      wr_addr = count_q[AW-1:0];
      wr_data = push_entry;
    end else if (cmd_i.pop_finish) begin
      // The last read is the last entry; it moves into the winner's slot.
      wr_en   = 1'b1;
      wr_addr = best_idx_d;
      wr_data = rd_data_q;
    end else if (cmd_i.scan && cmd_i.age_mode && rd_vld_q) begin
      wr_en = 1'b1;
    end
  end

  // Entry count.
  always_comb begin
    count_d = count_q;
    if (cmd_i.push) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.pop_finish) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      idx_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      count_q  <= count_d;
      idx_q    <= idx_d;
      rd_vld_q <= rd_en;
    end
  end

  // Memory array.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem[idx_q[AW-1:0]];
      rd_idx_q  <= idx_q[AW-1:0];
    end
  end

  // Search registers.
  always_ff @(posedge clk_i) begin
    best_q     <= best_d;
    best_idx_q <= best_idx_d;
  end

  // Pending result of the current command.
  always_ff @(posedge clk_i) begin
    if (cmd_i.pop_finish) begin
      res_status_q <= ST_DONE;
      res_item_q   <= best_d;
    end else if (cmd_i.set_res) begin
      res_status_q <= cmd_i.res_code;
      res_item_q   <= '0;
    end
  end

  // Output register: holds a finished transaction until it is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q <= '{status:       res_status_q,
                 out_depth:    res_item_q.depth,
                 out_severity: res_item_q.severity,
                 out_locality: res_item_q.locality,
                 out_weight:   res_item_q.weight,
                 out_age:      res_item_q.age,
                 out_id:       res_item_q.id,
                 occupancy:    7'(count_q)};
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // Status towards the controller.
  assign status_o = '{op:        item_q.opcode,
                      full:      (count_q == CW'(CAPACITY)),
                      empty:     (count_q == '0),
                      scan_last: scan_last,
                      out_free:  (!out_vld_q || !out_stall_i)};

`ifndef NO_ASSERTIONS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("Entry count exceeds capacity.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> (count_q != CW'(CAPACITY)))
    else $error("Push written into a full store.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop_finish |-> (rd_vld_q && (count_q != '0)))
    else $error("Pop completed without a valid scan result.");
`endif

endmodule
